>>> src/rgb_gaussian_blur_5x5_assert.svh
// ----------------------------------------------------------------------------
// rgb_gaussian_blur_5x5 assertion macros
// Concurrent assertion wrappers used at the end of the blur top level.
// ----------------------------------------------------------------------------
`ifndef RGB_GAUSSIAN_BLUR_5X5_ASSERT_SVH
`define RGB_GAUSSIAN_BLUR_5X5_ASSERT_SVH

// condition holds at every clock edge outside reset
`define RGBGB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RGBGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rgbgb_pkg.sv
// ----------------------------------------------------------------------------
// rgbgb_pkg
// Types, sizes and constants of the 5x5 gaussian blur pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbgb_pkg;

   localparam int MaxWidth     = 2048;
   localparam int MaxHeight    = 2048;
   localparam int AddrWidth    = $clog2(MaxWidth);
   localparam int RowWidth     = $clog2(MaxHeight);
   localparam int DimWidth     = 12;
   localparam int PendWidth    = DimWidth + 1;
   localparam int PendRowWidth = 3;
   localparam int ChanWidth    = 8;
   localparam int NumChans     = 3;
   localparam int ChanSelWidth = $clog2(NumChans);
   localparam int KernelSize   = 5;
   localparam int Half         = KernelSize / 2;
   localparam int NumSlots     = KernelSize - 1;
   localparam int SlotWidth    = $clog2(NumSlots);
   localparam int RowSumWidth  = 14;
   localparam int TotalWidth   = 15;
   localparam int WeightShift  = 4;
   localparam int QuotWidth    = TotalWidth - WeightShift;
   localparam int Div5Mult     = 3277;
   localparam int Div5MultWidth = 12;
   localparam int Div5Shift    = 14;
   localparam int ProdWidth    = QuotWidth + Div5MultWidth;
   localparam int FifoDepth    = 8;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = FifoPtrWidth + 1;

   localparam logic [DimWidth-1:0] ResetFrameWidth  = 12'd640;
   localparam logic [DimWidth-1:0] ResetFrameHeight = 12'd480;
   localparam logic [DimWidth-1:0] MaxWidthDim      = DimWidth'(MaxWidth);
   localparam logic [DimWidth-1:0] MaxHeightDim     = DimWidth'(MaxHeight);
   localparam logic [DimWidth-1:0] HalfDim          = DimWidth'(Half);

   localparam logic OpPixel = 1'b0;
   localparam logic OpDrain = 1'b1;

   localparam logic RegFrameWidth  = 1'b0;
   localparam logic RegFrameHeight = 1'b1;

   localparam logic [ChanSelWidth-1:0] ChanRed   = 2'd0;
   localparam logic [ChanSelWidth-1:0] ChanGreen = 2'd1;
   localparam logic [ChanSelWidth-1:0] ChanBlue  = 2'd2;

   localparam logic [4:0] KernelWeights [KernelSize][KernelSize] = '{
      '{5'd0, 5'd1, 5'd2,  5'd1, 5'd0},
      '{5'd1, 5'd4, 5'd8,  5'd4, 5'd1},
      '{5'd2, 5'd8, 5'd16, 5'd8, 5'd2},
      '{5'd1, 5'd4, 5'd8,  5'd4, 5'd1},
      '{5'd0, 5'd1, 5'd2,  5'd1, 5'd0}
   };

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } pixel_type;

   typedef pixel_type [NumSlots-1:0]   line_entry_type;
   typedef pixel_type [KernelSize-1:0] window_col_type;
   typedef logic [KernelSize-1:0][RowSumWidth-1:0] row_sums_type;

   typedef struct packed {
      logic                 valid;
      logic                 pixel;
      logic                 emit;
      logic                 filter;
      logic                 last;
      logic [SlotWidth-1:0] slot;
      logic [AddrWidth-1:0] addr;
      pixel_type            pix;
   } s1_type;

   typedef struct packed {
      logic      valid;
      logic      drain;
      logic      filter;
      logic      last;
      pixel_type pix;
   } s2_type;

   typedef struct packed {
      logic                        valid;
      logic                        filter;
      logic                        last;
      pixel_type                   pix;
      row_sums_type [NumChans-1:0] rows;
   } s3_type;

   typedef struct packed {
      logic                                valid;
      logic                                filter;
      logic                                last;
      pixel_type                           pix;
      logic [NumChans-1:0][QuotWidth-1:0]  quot;
   } s4_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } result_type;

   function automatic logic [ChanWidth-1:0] channel_of(input pixel_type pix,
                                                       input logic [ChanSelWidth-1:0] sel);
      logic [ChanWidth-1:0] val;
      case (sel)
         ChanRed:   val = pix.red;
         ChanGreen: val = pix.green;
         ChanBlue:  val = pix.blue;
         default:   val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> src/rgb_gaussian_blur_5x5.sv
// ----------------------------------------------------------------------------
// rgb_gaussian_blur_5x5: 5x5 gaussian blur over a raster rgb pixel stream
// Lag: results lag 2*width+2 pixels; each passes stages s1 to s4 into the result queue.
// Throughput: one beat per cycle while the result queue has credit, set by one line memory read and write per pixel.
// Reset: synchronous; line memory content stays undefined, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_gaussian_blur_5x5_assert.svh"

module rgb_gaussian_blur_5x5 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [rgbgb_pkg::ChanWidth-1:0]     req_in_red,
   input  logic [rgbgb_pkg::ChanWidth-1:0]     req_in_green,
   input  logic [rgbgb_pkg::ChanWidth-1:0]     req_in_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rgbgb_pkg::ChanWidth-1:0]     rsp_out_red,
   output logic [rgbgb_pkg::ChanWidth-1:0]     rsp_out_green,
   output logic [rgbgb_pkg::ChanWidth-1:0]     rsp_out_blue,
   output logic                                rsp_frame_last,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [rgbgb_pkg::DimWidth-1:0]      csr_wdata
);

   logic [rgbgb_pkg::DimWidth-1:0]     frame_width_ff;
   logic [rgbgb_pkg::DimWidth-1:0]     frame_height_ff;
   logic [rgbgb_pkg::DimWidth-1:0]     eff_width;
   logic [rgbgb_pkg::DimWidth-1:0]     eff_height;

   logic [rgbgb_pkg::AddrWidth-1:0]    in_col_ff, in_col_in;
   logic [rgbgb_pkg::PendWidth-1:0]    pend_ff, pend_in;
   logic [rgbgb_pkg::AddrWidth-1:0]    pend_col_ff, pend_col_in;
   logic [rgbgb_pkg::PendRowWidth-1:0] pend_row_ff, pend_row_in;
   logic [rgbgb_pkg::AddrWidth-1:0]    out_col_ff, out_col_in;
   logic [rgbgb_pkg::RowWidth-1:0]     out_row_ff, out_row_in;

   logic                               req_fire;
   logic                               is_pixel;
   logic                               emit;
   logic                               interior;
   logic                               at_last;
   logic [rgbgb_pkg::DimWidth-1:0]     col_ext;
   logic [rgbgb_pkg::DimWidth-1:0]     row_ext;
   logic [rgbgb_pkg::SlotWidth-1:0]    drain_slot;
   logic [rgbgb_pkg::AddrWidth-1:0]    rd_addr;

   rgbgb_pkg::line_entry_type          line_mem [rgbgb_pkg::MaxWidth];
   rgbgb_pkg::line_entry_type          mem_rd_ff;
   rgbgb_pkg::line_entry_type          entry;
   rgbgb_pkg::line_entry_type          mem_wdata;
   logic                               mem_we;
   logic                               wr_vld_ff;
   logic [rgbgb_pkg::AddrWidth-1:0]    wr_addr_ff;
   rgbgb_pkg::line_entry_type          wr_data_ff;

   rgbgb_pkg::window_col_type          window_ff [rgbgb_pkg::KernelSize];
   rgbgb_pkg::window_col_type          new_col;

   rgbgb_pkg::s1_type                  s1_ff, s1_in;
   rgbgb_pkg::s2_type                  s2_ff, s2_in;
   rgbgb_pkg::s3_type                  s3_ff, s3_in;
   rgbgb_pkg::s4_type                  s4_ff, s4_in;
   logic [rgbgb_pkg::TotalWidth-1:0]   total [rgbgb_pkg::NumChans];
   logic [rgbgb_pkg::ProdWidth-1:0]    prod [rgbgb_pkg::NumChans];
   rgbgb_pkg::result_type              result;

   rgbgb_pkg::result_type              fifo_mem_ff [rgbgb_pkg::FifoDepth];
   logic [rgbgb_pkg::FifoPtrWidth-1:0] fifo_wr_ff, fifo_rd_ff;
   logic [rgbgb_pkg::FifoCntWidth-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic                               fifo_push;
   logic                               fifo_pop;
   logic [rgbgb_pkg::PendRowWidth-1:0] inflight;
   logic [rgbgb_pkg::FifoCntWidth-1:0] occupancy;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgbgb_pkg::ResetFrameWidth;
         frame_height_ff <= rgbgb_pkg::ResetFrameHeight;
      end else if (csr_write) begin
         case (csr_index)
            rgbgb_pkg::RegFrameWidth:  frame_width_ff  <= csr_wdata;
            rgbgb_pkg::RegFrameHeight: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = rgbgb_pkg::DimWidth'(1);
      end else if (frame_width_ff > rgbgb_pkg::MaxWidthDim) begin
         eff_width = rgbgb_pkg::MaxWidthDim;
      end else begin
         eff_width = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         eff_height = rgbgb_pkg::DimWidth'(1);
      end else if (frame_height_ff > rgbgb_pkg::MaxHeightDim) begin
         eff_height = rgbgb_pkg::MaxHeightDim;
      end else begin
         eff_height = frame_height_ff;
      end
   end

   // credit against the result queue
   assign inflight  = rgbgb_pkg::PendRowWidth'(s1_ff.valid & s1_ff.emit)
                    + rgbgb_pkg::PendRowWidth'(s2_ff.valid)
                    + rgbgb_pkg::PendRowWidth'(s3_ff.valid)
                    + rgbgb_pkg::PendRowWidth'(s4_ff.valid);
   assign occupancy = fifo_cnt_ff + rgbgb_pkg::FifoCntWidth'(inflight);
   assign req_ready = occupancy < rgbgb_pkg::FifoCntWidth'(rgbgb_pkg::FifoDepth);
   assign req_fire  = req_valid && req_ready;

   // accept stage: position bookkeeping and line memory read
   always_comb begin
      is_pixel   = (req_opcode == rgbgb_pkg::OpPixel);
      col_ext    = rgbgb_pkg::DimWidth'(out_col_ff);
      row_ext    = rgbgb_pkg::DimWidth'(out_row_ff);
      interior   = (row_ext >= rgbgb_pkg::HalfDim)
                && (row_ext + rgbgb_pkg::HalfDim < eff_height)
                && (col_ext >= rgbgb_pkg::HalfDim)
                && (col_ext + rgbgb_pkg::HalfDim < eff_width);
      at_last    = (row_ext + rgbgb_pkg::DimWidth'(1) >= eff_height)
                && (col_ext + rgbgb_pkg::DimWidth'(1) >= eff_width);
      emit       = is_pixel ? (pend_ff > {eff_width, 1'b1}) : (pend_ff != '0);
      drain_slot = (pend_col_ff != '0) ? rgbgb_pkg::SlotWidth'(pend_row_ff)
                 : rgbgb_pkg::SlotWidth'(pend_row_ff - rgbgb_pkg::PendRowWidth'(1));
      rd_addr    = is_pixel ? in_col_ff : out_col_ff;

      in_col_in   = in_col_ff;
      pend_in     = pend_ff;
      pend_col_in = pend_col_ff;
      pend_row_in = pend_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;

      if (req_fire) begin
         if (is_pixel) begin
            if (rgbgb_pkg::DimWidth'(in_col_ff) + rgbgb_pkg::DimWidth'(1) >= eff_width) begin
               in_col_in = '0;
            end else begin
               in_col_in = in_col_ff + rgbgb_pkg::AddrWidth'(1);
            end
         end
         if (emit) begin
            if (col_ext + rgbgb_pkg::DimWidth'(1) >= eff_width) begin
               out_col_in = '0;
               if (row_ext + rgbgb_pkg::DimWidth'(1) >= eff_height) begin
                  out_row_in = '0;
               end else begin
                  out_row_in = out_row_ff + rgbgb_pkg::RowWidth'(1);
               end
            end else begin
               out_col_in = out_col_ff + rgbgb_pkg::AddrWidth'(1);
            end
         end
         if (is_pixel && !emit) begin
            pend_in = pend_ff + rgbgb_pkg::PendWidth'(1);
            if (rgbgb_pkg::DimWidth'(pend_col_ff) + rgbgb_pkg::DimWidth'(1) >= eff_width) begin
               pend_col_in = '0;
               pend_row_in = pend_row_ff + rgbgb_pkg::PendRowWidth'(1);
            end else begin
               pend_col_in = pend_col_ff + rgbgb_pkg::AddrWidth'(1);
            end
         end else if (!is_pixel && emit) begin
            pend_in = pend_ff - rgbgb_pkg::PendWidth'(1);
            if (pend_col_ff == '0) begin
               pend_col_in = rgbgb_pkg::AddrWidth'(eff_width - rgbgb_pkg::DimWidth'(1));
               pend_row_in = pend_row_ff - rgbgb_pkg::PendRowWidth'(1);
            end else begin
               pend_col_in = pend_col_ff - rgbgb_pkg::AddrWidth'(1);
            end
         end
      end

      s1_in.valid     = req_fire;
      s1_in.pixel     = is_pixel;
      s1_in.emit      = emit;
      s1_in.filter    = is_pixel && interior;
      s1_in.last      = at_last;
      s1_in.slot      = drain_slot;
      s1_in.addr      = rd_addr;
      s1_in.pix.red   = req_in_red;
      s1_in.pix.green = req_in_green;
      s1_in.pix.blue  = req_in_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         pend_ff     <= '0;
         pend_col_ff <= '0;
         pend_row_ff <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         pend_ff     <= pend_in;
         pend_col_ff <= pend_col_in;
         pend_row_ff <= pend_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
      end
   end

   // line memory: four older rows per column, newest in slot zero
   always_comb begin
      entry = (wr_vld_ff && (wr_addr_ff == s1_ff.addr)) ? wr_data_ff : mem_rd_ff;
      mem_we = s1_ff.valid && s1_ff.pixel;
      new_col[0]   = s1_ff.pix;
      mem_wdata[0] = s1_ff.pix;
      for (int s = 0; s < rgbgb_pkg::NumSlots; s++) begin
         new_col[s+1] = entry[s];
      end
      for (int s = 1; s < rgbgb_pkg::NumSlots; s++) begin
         mem_wdata[s] = entry[s-1];
      end

      s2_in.valid  = s1_ff.valid && s1_ff.emit;
      s2_in.drain  = !s1_ff.pixel;
      s2_in.filter = s1_ff.filter;
      s2_in.last   = s1_ff.last;
      s2_in.pix    = entry[s1_ff.slot];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_ff.addr] <= mem_wdata;
      end
      if (req_fire) begin
         mem_rd_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= s1_ff.addr;
      wr_data_ff <= mem_wdata;
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= mem_we;
      end
   end

   // 5x5 window, column zero newest
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_ff[0] <= new_col;
         for (int j = 1; j < rgbgb_pkg::KernelSize; j++) begin
            window_ff[j] <= window_ff[j-1];
         end
      end
   end

   // row sums
   always_comb begin
      s3_in.valid  = s2_ff.valid;
      s3_in.filter = s2_ff.filter;
      s3_in.last   = s2_ff.last;
      s3_in.pix    = s2_ff.drain ? s2_ff.pix : window_ff[rgbgb_pkg::Half][rgbgb_pkg::Half];
      for (int c = 0; c < rgbgb_pkg::NumChans; c++) begin
         for (int i = 0; i < rgbgb_pkg::KernelSize; i++) begin
            s3_in.rows[c][i] = '0;
            for (int j = 0; j < rgbgb_pkg::KernelSize; j++) begin
               s3_in.rows[c][i] = s3_in.rows[c][i]
                  + rgbgb_pkg::RowSumWidth'(rgbgb_pkg::KernelWeights[i][j])
                  * rgbgb_pkg::RowSumWidth'(rgbgb_pkg::channel_of(window_ff[j][i],
                                            rgbgb_pkg::ChanSelWidth'(c)));
            end
         end
      end
   end

   // total and divide by 16
   always_comb begin
      s4_in.valid  = s3_ff.valid;
      s4_in.filter = s3_ff.filter;
      s4_in.last   = s3_ff.last;
      s4_in.pix    = s3_ff.pix;
      for (int c = 0; c < rgbgb_pkg::NumChans; c++) begin
         total[c] = '0;
         for (int i = 0; i < rgbgb_pkg::KernelSize; i++) begin
            total[c] = total[c] + rgbgb_pkg::TotalWidth'(s3_ff.rows[c][i]);
         end
         s4_in.quot[c] = total[c][rgbgb_pkg::TotalWidth-1:rgbgb_pkg::WeightShift];
      end
   end

   // divide by 5 through reciprocal
   always_comb begin
      for (int c = 0; c < rgbgb_pkg::NumChans; c++) begin
         prod[c] = rgbgb_pkg::ProdWidth'(s4_ff.quot[c])
                 * rgbgb_pkg::ProdWidth'(rgbgb_pkg::Div5Mult);
      end
      result.last = s4_ff.last;
      if (s4_ff.filter) begin
         result.pix.red   = prod[0][rgbgb_pkg::Div5Shift +: rgbgb_pkg::ChanWidth];
         result.pix.green = prod[1][rgbgb_pkg::Div5Shift +: rgbgb_pkg::ChanWidth];
         result.pix.blue  = prod[2][rgbgb_pkg::Div5Shift +: rgbgb_pkg::ChanWidth];
      end else begin
         result.pix = s4_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   // result queue
   assign fifo_push   = s4_ff.valid;
   assign fifo_pop    = rsp_valid && rsp_ready;
   assign fifo_cnt_in = fifo_cnt_ff + rgbgb_pkg::FifoCntWidth'(fifo_push)
                      - rgbgb_pkg::FifoCntWidth'(fifo_pop);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem_ff[fifo_wr_ff] <= result;
      end
      if (reset) begin
         fifo_wr_ff  <= '0;
         fifo_rd_ff  <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push) begin
            fifo_wr_ff <= fifo_wr_ff + rgbgb_pkg::FifoPtrWidth'(1);
         end
         if (fifo_pop) begin
            fifo_rd_ff <= fifo_rd_ff + rgbgb_pkg::FifoPtrWidth'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   assign rsp_valid      = (fifo_cnt_ff != '0);
   assign rsp_out_red    = fifo_mem_ff[fifo_rd_ff].pix.red;
   assign rsp_out_green  = fifo_mem_ff[fifo_rd_ff].pix.green;
   assign rsp_out_blue   = fifo_mem_ff[fifo_rd_ff].pix.blue;
   assign rsp_frame_last = fifo_mem_ff[fifo_rd_ff].last;

   `RGBGB_ASSERT_ALWAYS(a_queue_credit, clock, reset, occupancy <= rgbgb_pkg::FifoCntWidth'(rgbgb_pkg::FifoDepth), "result queue credit exceeded")
   `RGBGB_ASSERT_NEXT(a_empty_drain, clock, reset, req_fire && (req_opcode == rgbgb_pkg::OpDrain) && (pend_ff == '0), !s1_ff.emit, "drain with nothing pending produced a result")

endmodule
